// File: hdl/rbve_pkg.sv
`timescale 1ns / 1ps
package rbve_pkg;
   localparam int COUNT_WIDTH      = 32;
   localparam int VARINT_MAX_BYTES = 10;
   localparam int HDR_BYTES        = 8 + 4 + 4 + 1;
   localparam int BFIX_BYTES       = 40;
   localparam int LNEXT_BYTES      = 17;
   localparam int LEN_BYTES        = 4;
   localparam logic [7:0] LOW7     = 8'h7F;
   localparam logic [7:0] CONT_BIT = 8'h80;
   localparam logic [7:0] MAGIC_V2 = 8'd2;

   localparam logic [1:0] ST_COMPLETE  = 2'd0;
   localparam logic [1:0] ST_TRUNCATED = 2'd1;
   localparam logic [1:0] ST_VARINT    = 2'd2;

   typedef enum logic [4:0] {
      PH_HDR, PH_LATTR, PH_LKLEN, PH_LKSKIP, PH_LVLEN, PH_LVAL, PH_LNEXT,
      PH_BFIX, PH_BCNT, PH_RLEN, PH_RATTR, PH_RTS, PH_ROFF, PH_RKLEN,
      PH_RKSKIP, PH_RVLEN, PH_RVAL, PH_RHCNT, PH_HKLEN, PH_HKSKIP,
      PH_HVLEN, PH_HVSKIP, PH_END, PH_ERR
   } phase_type;

   typedef logic [COUNT_WIDTH-1:0] count_type;

   typedef struct packed {
      logic [7:0]  value_byte;
      logic        value_valid;
      logic        value_first;
      logic        value_last;
      logic        batch_done;
      logic [1:0]  batch_status;
      logic        legacy_format;
      logic [63:0] start_offset;
   } rsp_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       buffer_last;
   } req_type;

   function automatic count_type sat(input logic [63:0] v);
      if (COUNT_WIDTH < 64 && (v >> COUNT_WIDTH) != 64'd0) sat = '1;
      else sat = count_type'(v);
   endfunction
endpackage

// File: hdl/rbve_if.sv
`timescale 1ns / 1ps
interface rbve_req_if;
   logic                 valid;
   logic                 ready;
   rbve_pkg::req_type    payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface rbve_rsp_if;
   logic                 valid;
   logic                 ready;
   rbve_pkg::rsp_type    payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/rbve_fifo.sv
`timescale 1ns / 1ps
// two-entry queue between parser and output
module rbve_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  rbve_pkg::rsp_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output rbve_pkg::rsp_type out_data
);
   rbve_pkg::rsp_type mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = cnt_ff != 2'd2;
   assign out_valid = cnt_ff != 2'd0;
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_data;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= ~wp_ff;
         if (pop)  rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

// File: hdl/rbve_parser.sv
`timescale 1ns / 1ps
// byte classifier: one byte a cycle while step is high
module rbve_parser (
   input  logic              clock,
   input  logic              reset,
   input  logic              step,
   input  rbve_pkg::req_type req,
   output logic              emit,
   output rbve_pkg::rsp_type rsp
);
   rbve_pkg::phase_type phase_ff, phase_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [63:0] acc_ff, acc_in;
   logic [6:0]  shift_ff, shift_in;
   rbve_pkg::count_type bytes_ff, bytes_in, recs_ff, recs_in, hdrs_ff, hdrs_in;
   logic [7:0]  magic_ff, magic_in;
   logic [63:0] base_ff, base_in;
   logic [1:0]  err_ff, err_in;
   logic        first_ff, first_in;

   logic [7:0]  b;
   logic [5:0]  cnt1;
   logic [63:0] acc_fix, acc_var;
   logic [31:0] w32;
   rbve_pkg::count_type pos_len, zz_len, bytes_dec, recs_dec, hdrs_dec;
   logic        vv, vf, vl, legacy;
   logic [1:0]  status;

   always_comb begin
      b        = req.data_byte;
      cnt1     = cnt_ff + 6'd1;
      acc_fix  = {acc_ff[55:0], b};
      w32      = acc_fix[31:0];
      pos_len  = w32[31] ? '0 : rbve_pkg::sat({33'd0, w32[30:0]});
      acc_var  = acc_ff | ({57'd0, b[6:0] & rbve_pkg::LOW7[6:0]} << shift_ff[5:0]);
      zz_len   = acc_var[0] ? '0 : rbve_pkg::sat({1'b0, acc_var[63:1]});
      bytes_dec = (bytes_ff != '0) ? bytes_ff - rbve_pkg::count_type'(1) : bytes_ff;
      phase_in = phase_ff; cnt_in = cnt_ff; acc_in = acc_ff; shift_in = shift_ff;
      bytes_in = bytes_ff; recs_in = recs_ff; hdrs_in = hdrs_ff;
      magic_in = magic_ff; base_in = base_ff; err_in = err_ff; first_in = first_ff;
      vv = 1'b0; vf = 1'b0; vl = 1'b0;
      recs_dec = '0; hdrs_dec = '0;
      case (phase_ff)
         rbve_pkg::PH_HDR: begin
            if (cnt_ff < 6'd8) base_in = {base_ff[55:0], b};
            cnt_in = cnt1;
            if (cnt1 >= 6'(rbve_pkg::HDR_BYTES)) begin
               cnt_in = '0; magic_in = b;
               if (b >= rbve_pkg::CONT_BIT || b < rbve_pkg::MAGIC_V2) begin
                  bytes_in = (b == 8'd1) ? rbve_pkg::count_type'(9) : rbve_pkg::count_type'(1);
                  phase_in = rbve_pkg::PH_LATTR; first_in = 1'b1;
               end else phase_in = rbve_pkg::PH_BFIX;
            end
         end
         rbve_pkg::PH_LATTR, rbve_pkg::PH_LKSKIP, rbve_pkg::PH_RKSKIP,
         rbve_pkg::PH_HKSKIP, rbve_pkg::PH_HVSKIP: begin
            bytes_in = bytes_dec;
            if (bytes_dec == '0) begin
               case (phase_ff)
                  rbve_pkg::PH_LATTR:  phase_in = rbve_pkg::PH_LKLEN;
                  rbve_pkg::PH_LKSKIP: phase_in = rbve_pkg::PH_LVLEN;
                  rbve_pkg::PH_RKSKIP: phase_in = rbve_pkg::PH_RVLEN;
                  rbve_pkg::PH_HKSKIP: phase_in = rbve_pkg::PH_HVLEN;
                  default: begin
                     hdrs_dec = (hdrs_ff != '0) ? hdrs_ff - rbve_pkg::count_type'(1)
                                                : hdrs_ff;
                     hdrs_in = hdrs_dec;
                     if (hdrs_dec != '0) phase_in = rbve_pkg::PH_HKLEN;
                     else begin
                        recs_dec = (recs_ff != '0) ? recs_ff - rbve_pkg::count_type'(1)
                                                   : recs_ff;
                        recs_in = recs_dec;
                        phase_in = (recs_dec != '0) ? rbve_pkg::PH_RLEN : rbve_pkg::PH_END;
                     end
                  end
               endcase
            end
         end
         rbve_pkg::PH_LKLEN, rbve_pkg::PH_LVLEN, rbve_pkg::PH_BCNT: begin
            acc_in = acc_fix; cnt_in = cnt1;
            if (cnt1 >= 6'(rbve_pkg::LEN_BYTES)) begin
               cnt_in = '0; acc_in = '0; first_in = 1'b1; bytes_in = pos_len;
               case (phase_ff)
                  rbve_pkg::PH_LKLEN:
                     phase_in = (pos_len != '0) ? rbve_pkg::PH_LKSKIP : rbve_pkg::PH_LVLEN;
                  rbve_pkg::PH_LVLEN:
                     phase_in = (pos_len != '0) ? rbve_pkg::PH_LVAL : rbve_pkg::PH_LNEXT;
                  default: begin
                     bytes_in = bytes_ff; first_in = first_ff; recs_in = pos_len;
                     phase_in = (pos_len != '0) ? rbve_pkg::PH_RLEN : rbve_pkg::PH_END;
                  end
               endcase
            end
         end
         rbve_pkg::PH_LVAL, rbve_pkg::PH_RVAL: begin
            vv = 1'b1; vf = first_ff; first_in = 1'b0; bytes_in = bytes_dec;
            if (bytes_dec == '0) begin
               vl = 1'b1;
               phase_in = (phase_ff == rbve_pkg::PH_LVAL) ? rbve_pkg::PH_LNEXT
                                                          : rbve_pkg::PH_RHCNT;
            end
         end
         rbve_pkg::PH_LNEXT: begin
            cnt_in = cnt1;
            if (cnt1 >= 6'(rbve_pkg::LNEXT_BYTES)) begin
               cnt_in = '0; magic_in = b; first_in = 1'b1;
               bytes_in = (b == 8'd1) ? rbve_pkg::count_type'(9) : rbve_pkg::count_type'(1);
               phase_in = rbve_pkg::PH_LATTR;
            end
         end
         rbve_pkg::PH_BFIX: begin
            cnt_in = cnt1;
            if (cnt1 >= 6'(rbve_pkg::BFIX_BYTES)) begin
               cnt_in = '0; phase_in = rbve_pkg::PH_BCNT;
            end
         end
         rbve_pkg::PH_RATTR: phase_in = rbve_pkg::PH_RTS;
         rbve_pkg::PH_RLEN, rbve_pkg::PH_RTS, rbve_pkg::PH_ROFF, rbve_pkg::PH_RKLEN,
         rbve_pkg::PH_RVLEN, rbve_pkg::PH_RHCNT, rbve_pkg::PH_HKLEN,
         rbve_pkg::PH_HVLEN: begin
            acc_in = acc_var; cnt_in = cnt1;
            if ((b & rbve_pkg::CONT_BIT) == 8'd0) begin
               acc_in = '0; shift_in = '0; cnt_in = '0;
               case (phase_ff)
                  rbve_pkg::PH_RLEN: phase_in = rbve_pkg::PH_RATTR;
                  rbve_pkg::PH_RTS:  phase_in = rbve_pkg::PH_ROFF;
                  rbve_pkg::PH_ROFF: phase_in = rbve_pkg::PH_RKLEN;
                  rbve_pkg::PH_RKLEN: begin
                     bytes_in = zz_len; first_in = 1'b1;
                     phase_in = (zz_len != '0) ? rbve_pkg::PH_RKSKIP : rbve_pkg::PH_RVLEN;
                  end
                  rbve_pkg::PH_RVLEN: begin
                     bytes_in = zz_len; first_in = 1'b1;
                     phase_in = (zz_len != '0) ? rbve_pkg::PH_RVAL : rbve_pkg::PH_RHCNT;
                  end
                  rbve_pkg::PH_HKLEN: begin
                     bytes_in = zz_len; first_in = 1'b1;
                     phase_in = (zz_len != '0) ? rbve_pkg::PH_HKSKIP : rbve_pkg::PH_HVLEN;
                  end
                  rbve_pkg::PH_RHCNT: begin
                     hdrs_in = rbve_pkg::sat(acc_var);
                     if (acc_var != 64'd0) phase_in = rbve_pkg::PH_HKLEN;
                     else begin
                        recs_dec = (recs_ff != '0) ? recs_ff - rbve_pkg::count_type'(1)
                                                   : recs_ff;
                        recs_in = recs_dec;
                        phase_in = (recs_dec != '0) ? rbve_pkg::PH_RLEN : rbve_pkg::PH_END;
                     end
                  end
                  default: begin
                     bytes_in = zz_len;
                     if (zz_len != '0) phase_in = rbve_pkg::PH_HVSKIP;
                     else begin
                        hdrs_dec = (hdrs_ff != '0) ? hdrs_ff - rbve_pkg::count_type'(1)
                                                   : hdrs_ff;
                        hdrs_in = hdrs_dec;
                        if (hdrs_dec != '0) phase_in = rbve_pkg::PH_HKLEN;
                        else begin
                           recs_dec = (recs_ff != '0)
                                    ? recs_ff - rbve_pkg::count_type'(1) : recs_ff;
                           recs_in = recs_dec;
                           phase_in = (recs_dec != '0) ? rbve_pkg::PH_RLEN
                                                       : rbve_pkg::PH_END;
                        end
                     end
                  end
               endcase
            end else if (cnt1 >= 6'(rbve_pkg::VARINT_MAX_BYTES)) begin
               err_in = rbve_pkg::ST_VARINT; phase_in = rbve_pkg::PH_ERR;
            end else shift_in = shift_ff + 7'd7;
         end
         default: ;
      endcase

      legacy = phase_in >= rbve_pkg::PH_LATTR && phase_in <= rbve_pkg::PH_LNEXT;
      if (err_in != 2'd0) status = rbve_pkg::ST_VARINT;
      else if (phase_in == rbve_pkg::PH_END ||
               (phase_in == rbve_pkg::PH_LNEXT && cnt_in == 6'd0))
         status = rbve_pkg::ST_COMPLETE;
      else status = rbve_pkg::ST_TRUNCATED;

      emit = vv || req.buffer_last;
      rsp.value_byte    = vv ? b : 8'd0;
      rsp.value_valid   = vv;
      rsp.value_first   = vf;
      rsp.value_last    = vl;
      rsp.batch_done    = req.buffer_last;
      rsp.batch_status  = req.buffer_last ? status : 2'd0;
      rsp.legacy_format = req.buffer_last && legacy;
      rsp.start_offset  = req.buffer_last ? base_in : 64'd0;
   end

   always_ff @(posedge clock) begin
      if (reset || (step && req.buffer_last)) begin
         phase_ff <= rbve_pkg::PH_HDR; cnt_ff <= '0; acc_ff <= '0; shift_ff <= '0;
         bytes_ff <= '0; recs_ff <= '0; hdrs_ff <= '0; magic_ff <= '0;
         base_ff <= '0; err_ff <= '0; first_ff <= 1'b0;
      end else if (step) begin
         phase_ff <= phase_in; cnt_ff <= cnt_in; acc_ff <= acc_in; shift_ff <= shift_in;
         bytes_ff <= bytes_in; recs_ff <= recs_in; hdrs_ff <= hdrs_in;
         magic_ff <= magic_in; base_ff <= base_in; err_ff <= err_in; first_ff <= first_in;
      end
   end
endmodule

// File: hdl/record_batch_value_extractor_unit.sv
`timescale 1ns / 1ps
// channel | dir | contents
// req     | in  | data_byte, buffer_last
// rsp     | out | value byte with first/last marks, done status, base offset
//
// one byte accepted every cycle unless the input stalls; the parser state advances at the accepting edge
// the result is held in a staging register, then enters the output queue
// reset is synchronous and returns the parser to the batch header phase
// input stalls only while the staging register holds a result the full queue refuses
module record_batch_value_extractor_unit (
   input logic   clock,
   input logic   reset,
   rbve_req_if.sink   req,
   rbve_rsp_if.source rsp
);
   // front stage registers the parser's result
   rbve_pkg::rsp_type res_ff;
   logic              res_valid_ff;
   logic              q_ready;
   logic              step, emit;
   rbve_pkg::rsp_type res;

   // accept whenever the staging register can drain or is empty
   assign req.ready = !res_valid_ff || q_ready;
   assign step      = req.valid && req.ready;

   rbve_parser u_parser (
      .clock (clock), .reset (reset), .step (step),
      .req (req.payload), .emit (emit), .rsp (res)
   );

   always_ff @(posedge clock) begin
      if (step) res_ff <= res;
      if (reset) res_valid_ff <= 1'b0;
      else if (req.ready) res_valid_ff <= step && emit;
   end

   // back part: queue decouples parser from the result consumer
   rbve_fifo u_fifo (
      .clock (clock), .reset (reset),
      .in_valid (res_valid_ff), .in_ready (q_ready), .in_data (res_ff),
      .out_valid (rsp.valid), .out_ready (rsp.ready), .out_data (rsp.payload)
   );
endmodule

// File: tb/record_batch_value_extractor_unit_tb.sv
`timescale 1ns / 1ps
module record_batch_value_extractor_unit_tb;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int TARGET_BYTES = 1100;

   typedef struct {
      logic [7:0] data;
      logic       last;
      logic       drain;   // hold off until every due result has arrived
   } byte_slot_type;

   logic clock = 1'b0;
   logic reset;

   rbve_req_if req ();
   rbve_rsp_if rsp ();

   record_batch_value_extractor_unit u_top (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // byte stream waiting to go, buffer under construction, results due
   byte_slot_type        byte_stream[$];
   logic [7:0]           frame[$];
   rbve_pkg::rsp_type    results_due[$];
   int                   failures   = 0;
   int                   n_accepted = 0;
   int                   n_cycles   = 0;
   int                   n_buffers  = 0;

   // parser shadow state
   rbve_pkg::phase_type  ph = rbve_pkg::PH_HDR;
   int                   fbc = 0;
   logic [63:0]          acc = '0;
   int                   vshift = 0;
   logic [63:0]          brem = '0, rrem = '0, hrem = '0;
   logic [7:0]           magic = '0;
   logic [63:0]          boff = '0;
   logic [1:0]           errf = '0;
   bit                   first_pend = 1'b0;

   function automatic logic [63:0] clamp_count(logic [63:0] v);
      logic [63:0] cap;
      cap = (rbve_pkg::COUNT_WIDTH >= 64) ? '1
          : ((64'd1 << rbve_pkg::COUNT_WIDTH) - 64'd1);
      return (v > cap) ? cap : v;
   endfunction

   function automatic logic [63:0] zz_len(logic [63:0] raw);
      return raw[0] ? 64'd0 : clamp_count(raw >> 1);
   endfunction

   function automatic logic [63:0] pos_len(logic [63:0] v);
      return v[31] ? 64'd0 : clamp_count({33'd0, v[30:0]});
   endfunction

   function automatic void clear_parser();
      ph = rbve_pkg::PH_HDR; fbc = 0; acc = '0; vshift = 0;
      brem = '0; rrem = '0; hrem = '0; magic = '0; boff = '0;
      errf = '0; first_pend = 1'b0;
   endfunction

   function automatic void open_skip(logic [63:0] n, rbve_pkg::phase_type sp,
                                     rbve_pkg::phase_type np);
      brem = n;
      ph = (n != 64'd0) ? sp : np;
      first_pend = 1'b1;
   endfunction

   function automatic void close_record();
      if (rrem != 64'd0) rrem = rrem - 64'd1;
      ph = (rrem != 64'd0) ? rbve_pkg::PH_RLEN : rbve_pkg::PH_END;
   endfunction

   function automatic void close_header();
      if (hrem != 64'd0) hrem = hrem - 64'd1;
      if (hrem != 64'd0) ph = rbve_pkg::PH_HKLEN;
      else close_record();
   endfunction

   function automatic void open_legacy_msg();
      open_skip((magic == 8'd1) ? 64'd9 : 64'd1, rbve_pkg::PH_LATTR, rbve_pkg::PH_LKLEN);
   endfunction

   // fixed big-endian field; 1 when n bytes gathered
   function automatic bit gather_fixed(logic [7:0] b, int n);
      acc = (acc << 8) | {56'd0, b};
      fbc = (fbc + 1) & 63;
      if (fbc >= n) begin
         fbc = 0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // advance the parser by one byte and queue any result it gives
   function automatic void parse_byte(logic [7:0] b, logic last);
      bit                vv, vf, vl, done;
      logic [63:0]       v;
      rbve_pkg::rsp_type r;
      vv = 0; vf = 0; vl = 0; done = 0; v = '0;
      case (ph)
         rbve_pkg::PH_HDR: begin
            if (fbc < 8) boff = (boff << 8) | {56'd0, b};
            fbc = (fbc + 1) & 63;
            if (fbc >= rbve_pkg::HDR_BYTES) begin
               fbc = 0;
               magic = b;
               if (b >= 8'h80 || b < rbve_pkg::MAGIC_V2) open_legacy_msg();
               else ph = rbve_pkg::PH_BFIX;
            end
         end
         rbve_pkg::PH_LATTR, rbve_pkg::PH_LKSKIP, rbve_pkg::PH_RKSKIP,
         rbve_pkg::PH_HKSKIP, rbve_pkg::PH_HVSKIP: begin
            if (brem != 64'd0) brem = brem - 64'd1;
            if (brem == 64'd0) begin
               case (ph)
                  rbve_pkg::PH_LATTR:  ph = rbve_pkg::PH_LKLEN;
                  rbve_pkg::PH_LKSKIP: ph = rbve_pkg::PH_LVLEN;
                  rbve_pkg::PH_RKSKIP: ph = rbve_pkg::PH_RVLEN;
                  rbve_pkg::PH_HKSKIP: ph = rbve_pkg::PH_HVLEN;
                  default:             close_header();
               endcase
            end
         end
         rbve_pkg::PH_LKLEN:
            if (gather_fixed(b, rbve_pkg::LEN_BYTES)) begin
               v = acc; acc = '0;
               open_skip(pos_len(v), rbve_pkg::PH_LKSKIP, rbve_pkg::PH_LVLEN);
            end
         rbve_pkg::PH_LVLEN:
            if (gather_fixed(b, rbve_pkg::LEN_BYTES)) begin
               v = acc; acc = '0;
               open_skip(pos_len(v), rbve_pkg::PH_LVAL, rbve_pkg::PH_LNEXT);
            end
         rbve_pkg::PH_LVAL, rbve_pkg::PH_RVAL: begin
            vv = 1; vf = first_pend; first_pend = 0;
            if (brem != 64'd0) brem = brem - 64'd1;
            if (brem == 64'd0) begin
               vl = 1;
               ph = (ph == rbve_pkg::PH_LVAL) ? rbve_pkg::PH_LNEXT : rbve_pkg::PH_RHCNT;
            end
         end
         rbve_pkg::PH_LNEXT: begin
            fbc = (fbc + 1) & 63;
            if (fbc >= rbve_pkg::LNEXT_BYTES) begin
               fbc = 0;
               magic = b;
               open_legacy_msg();
            end
         end
         rbve_pkg::PH_BFIX: begin
            fbc = (fbc + 1) & 63;
            if (fbc >= rbve_pkg::BFIX_BYTES) begin
               fbc = 0;
               ph = rbve_pkg::PH_BCNT;
            end
         end
         rbve_pkg::PH_BCNT:
            if (gather_fixed(b, rbve_pkg::LEN_BYTES)) begin
               v = acc; acc = '0;
               rrem = pos_len(v);
               ph = (rrem != 64'd0) ? rbve_pkg::PH_RLEN : rbve_pkg::PH_END;
            end
         rbve_pkg::PH_RATTR: ph = rbve_pkg::PH_RTS;
         rbve_pkg::PH_RLEN, rbve_pkg::PH_RTS, rbve_pkg::PH_ROFF, rbve_pkg::PH_RKLEN,
         rbve_pkg::PH_RVLEN, rbve_pkg::PH_RHCNT, rbve_pkg::PH_HKLEN,
         rbve_pkg::PH_HVLEN: begin
            // varint: low seven bits land at the running shift
            acc = acc | ({56'd0, b & rbve_pkg::LOW7} << (vshift & 63));
            fbc = (fbc + 1) & 63;
            if ((b & rbve_pkg::CONT_BIT) == 8'd0) begin
               v = acc; acc = '0; vshift = 0; fbc = 0; done = 1;
            end else if (fbc >= rbve_pkg::VARINT_MAX_BYTES) begin
               errf = rbve_pkg::ST_VARINT;
               ph = rbve_pkg::PH_ERR;
            end else begin
               vshift = vshift + 7;
            end
            if (done) begin
               case (ph)
                  rbve_pkg::PH_RLEN:  ph = rbve_pkg::PH_RATTR;
                  rbve_pkg::PH_RTS:   ph = rbve_pkg::PH_ROFF;
                  rbve_pkg::PH_ROFF:  ph = rbve_pkg::PH_RKLEN;
                  rbve_pkg::PH_RKLEN:
                     open_skip(zz_len(v), rbve_pkg::PH_RKSKIP, rbve_pkg::PH_RVLEN);
                  rbve_pkg::PH_RVLEN:
                     open_skip(zz_len(v), rbve_pkg::PH_RVAL, rbve_pkg::PH_RHCNT);
                  rbve_pkg::PH_RHCNT: begin
                     hrem = clamp_count(v);
                     if (hrem != 64'd0) ph = rbve_pkg::PH_HKLEN;
                     else close_record();
                  end
                  rbve_pkg::PH_HKLEN:
                     open_skip(zz_len(v), rbve_pkg::PH_HKSKIP, rbve_pkg::PH_HVLEN);
                  default: begin
                     brem = zz_len(v);
                     if (brem != 64'd0) ph = rbve_pkg::PH_HVSKIP;
                     else close_header();
                  end
               endcase
            end
         end
         default: ;
      endcase

      if (!vv && !last) return;
      r = '0;
      r.value_byte  = vv ? b : 8'd0;
      r.value_valid = vv;
      r.value_first = vf;
      r.value_last  = vl;
      if (last) begin
         r.batch_done = 1'b1;
         if (errf != 2'd0) r.batch_status = rbve_pkg::ST_VARINT;
         else if (ph == rbve_pkg::PH_END || (ph == rbve_pkg::PH_LNEXT && fbc == 0))
            r.batch_status = rbve_pkg::ST_COMPLETE;
         else r.batch_status = rbve_pkg::ST_TRUNCATED;
         r.legacy_format = (ph >= rbve_pkg::PH_LATTR && ph <= rbve_pkg::PH_LNEXT);
         r.start_offset  = boff;
         clear_parser();
      end
      results_due.insert(results_due.size(), r);
   endfunction

   // ---------------- buffer builders ----------------
   function automatic void add_byte(logic [7:0] b);
      frame.insert(frame.size(), b);
   endfunction

   function automatic void put_fixed(logic [63:0] v, int n);
      for (int i = n - 1; i >= 0; i--) add_byte(v[8*i +: 8]);
   endfunction

   function automatic void put_noise(int n);
      for (int i = 0; i < n; i++) add_byte(8'($urandom));
   endfunction

   function automatic void put_varint(logic [63:0] v);
      do begin
         add_byte({(v > 64'h7F), v[6:0]});
         v = v >> 7;
      end while (v != 0);
   endfunction

   // zigzag length; negative encodes as an odd raw value
   function automatic void put_zz(int n);
      if (n < 0) put_varint(64'(-2 * longint'(n) - 1));
      else put_varint(64'(2 * n));
   endfunction

   // mostly short lengths, with zeros and negatives mixed in
   function automatic int pick_len();
      int k;
      k = $urandom_range(9);
      if (k < 2) return -int'($urandom_range(1, 1000000));
      if (k < 4) return 0;
      return $urandom_range(1, 6);
   endfunction

   function automatic logic [63:0] pick_offset();
      return {$urandom, $urandom};
   endfunction

   function automatic void put_batch_hdr(logic [63:0] offset, logic [7:0] mg);
      put_fixed(offset, 8);
      put_noise(8);         // batch length and epoch
      add_byte(mg);
   endfunction

   function automatic void put_legacy_msg(logic [7:0] mg);
      int kl, vl;
      put_noise((mg == 8'd1) ? 9 : 1);
      kl = pick_len();
      put_fixed(64'(kl), 4);
      if (kl > 0) put_noise(kl);
      vl = pick_len();
      put_fixed(64'(vl), 4);
      if (vl > 0) put_noise(vl);
   endfunction

   function automatic void build_legacy(logic [7:0] mg, int nmsg);
      logic [7:0] m;
      m = mg;
      put_batch_hdr(pick_offset(), mg);
      for (int i = 0; i < nmsg; i++) begin
         if (i > 0) begin
            put_noise(16);
            m = 8'($urandom_range(1));
            add_byte(m);
         end
         put_legacy_msg(m);
      end
   endfunction

   function automatic logic [63:0] pick_varint_value();
      return {$urandom, $urandom} >> $urandom_range(63);
   endfunction

   function automatic void put_record();
      int kl, vl, nh;
      put_varint(pick_varint_value());
      put_noise(1);
      put_varint(pick_varint_value());
      put_varint(pick_varint_value());
      kl = pick_len(); put_zz(kl); if (kl > 0) put_noise(kl);
      vl = pick_len(); put_zz(vl); if (vl > 0) put_noise(vl);
      nh = $urandom_range(2);
      put_varint(64'(nh));
      for (int h = 0; h < nh; h++) begin
         kl = pick_len(); put_zz(kl); if (kl > 0) put_noise(kl);
         vl = pick_len(); put_zz(vl); if (vl > 0) put_noise(vl);
      end
   endfunction

   function automatic void build_v2(int nrec, logic [31:0] count_field);
      put_batch_hdr(pick_offset(), 8'($urandom_range(2, 127)));
      put_noise(rbve_pkg::BFIX_BYTES);
      put_fixed(64'(count_field), 4);
      for (int i = 0; i < nrec; i++) put_record();
   endfunction

   // move the frame into the byte stream, marking its final byte
   function automatic void queue_frame(bit drain);
      byte_slot_type s;
      for (int i = 0; i < frame.size(); i++) begin
         s.data  = frame[i];
         s.last  = (i == frame.size() - 1);
         s.drain = drain && (i == 0);
         byte_stream.insert(byte_stream.size(), s);
      end
      frame.delete();
      n_buffers++;
   endfunction

   // ---------------- driver ----------------
   function automatic bit idle_now(int n);
      // stretch with no idle cycles in the middle of the run
      if (n >= 300 && n < 650) return 1'b0;
      return ($urandom_range(99) < 11);
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req.valid   <= 1'b0;
         req.payload <= '0;
      end else begin
         if (req.valid && req.ready) begin
            parse_byte(req.payload.data_byte, req.payload.buffer_last);
            n_accepted++;
         end
         if (!req.valid || req.ready) begin
            if (byte_stream.size() > 0 && !idle_now(n_accepted) &&
                !(byte_stream[0].drain && results_due.size() > 0)) begin
               req.valid   <= 1'b1;
               req.payload <= '{data_byte: byte_stream[0].data,
                                buffer_last: byte_stream[0].last};
               void'(byte_stream.pop_front());
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------- monitor ----------------
   always @(posedge clock) begin
      rbve_pkg::rsp_type got, want;
      if (reset) begin
         rsp.ready <= 1'b1;
      end else begin
         if (rsp.valid && rsp.ready) begin
            got = rsp.payload;
            if (results_due.size() == 0) begin
               $error("unexpected result item: %p", got);
               failures++;
            end else begin
               want = results_due.pop_front();
               if (got.value_byte !== want.value_byte) begin
                  $error("value_byte exp %0h got %0h", want.value_byte, got.value_byte);
                  failures++;
               end
               if (got.value_valid !== want.value_valid) begin
                  $error("value_valid exp %0b got %0b", want.value_valid, got.value_valid);
                  failures++;
               end
               if (got.value_first !== want.value_first) begin
                  $error("value_first exp %0b got %0b", want.value_first, got.value_first);
                  failures++;
               end
               if (got.value_last !== want.value_last) begin
                  $error("value_last exp %0b got %0b", want.value_last, got.value_last);
                  failures++;
               end
               if (got.batch_done !== want.batch_done) begin
                  $error("batch_done exp %0b got %0b", want.batch_done, got.batch_done);
                  failures++;
               end
               if (got.batch_status !== want.batch_status) begin
                  $error("batch_status exp %0d got %0d", want.batch_status,
                         got.batch_status);
                  failures++;
               end
               if (got.legacy_format !== want.legacy_format) begin
                  $error("legacy_format exp %0b got %0b", want.legacy_format,
                         got.legacy_format);
                  failures++;
               end
               if (got.start_offset !== want.start_offset) begin
                  $error("start_offset exp %0h got %0h", want.start_offset,
                         got.start_offset);
                  failures++;
               end
            end
         end
         rsp.ready <= !idle_now(n_accepted);
      end
   end

   // ---------------- watchdog ----------------
   always @(posedge clock) begin
      n_cycles++;
      if (n_cycles > CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ---------------- stimulus ----------------
   initial begin
      int k;
      int nrec;
      reset = 1'b1;

      // partial header: offset only partly received
      put_noise(5);
      queue_frame(0);
      // extreme offsets, legacy magic 0, 1 and a high magic
      put_batch_hdr(64'hFFFF_FFFF_FFFF_FFFF, 8'd0);
      put_fixed(64'h00, 1);
      put_fixed(64'hFFFF_FFFF, 4);            // negative key length
      put_fixed(64'd3, 4);
      put_noise(3);
      queue_frame(0);
      put_batch_hdr(64'h8000_0000_0000_0000, 8'd1);
      put_legacy_msg(8'd1);
      put_noise(16); add_byte(8'd0);
      put_legacy_msg(8'd0);
      queue_frame(0);
      build_legacy(8'h80, 2);
      queue_frame(0);
      // record batch with zero count, then negative count plus trailing bytes
      build_v2(0, 32'd0);
      queue_frame(0);
      build_v2(0, 32'h8000_0000);
      put_noise(3);
      queue_frame(0);
      // record with a negative value length and one header
      build_v2(0, 32'd1);
      put_varint(64'd20); put_noise(1); put_varint(64'd0); put_varint(64'd1);
      put_zz(0); put_zz(-1); put_varint(64'd1); put_zz(2); put_noise(2); put_zz(1);
      put_noise(1);
      queue_frame(1);
      // overlong varint, then bytes after it are ignored
      build_v2(0, 32'd2);
      for (int i = 0; i < rbve_pkg::VARINT_MAX_BYTES + 3; i++) add_byte(8'hFF);
      queue_frame(0);
      // huge value length with bits past bit 63, cut short
      build_v2(0, 32'd1);
      put_varint(64'd5); put_noise(1); put_varint(64'd0); put_varint(64'd0);
      put_zz(0);
      for (int i = 0; i < 9; i++) add_byte(8'hFE);
      add_byte(8'h7E);
      put_noise(4);
      queue_frame(0);

      // random buffers: mostly well formed, some pure noise
      while (byte_stream.size() < TARGET_BYTES) begin
         k = $urandom_range(99);
         if (k < 45) begin
            nrec = $urandom_range(1, 4);
            build_v2(nrec, 32'(nrec));
         end
         else if (k < 80) build_legacy(8'($urandom_range(1)), $urandom_range(1, 3));
         else put_noise($urandom_range(1, 80));
         queue_frame((n_buffers % 8) == 0);
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (byte_stream.size() > 0 || req.valid || results_due.size() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (failures == 0 && results_due.size() == 0) $display("*** PASSED ***");
      else $display("*** FAILED ***");
      $finish;
   end

endmodule
